@@ src/mlfq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int PRIO_W  = 8;
  localparam int LEVEL_W = 2;
  localparam int STAMP_W = 16;
  localparam int CFG_W   = 8;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DISPATCH = 2'd1,
    MODE_AGE      = 2'd2,
    MODE_NOP      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_UPPER  = 2'd0,
    CFG_MIDDLE = 2'd1,
    CFG_STEP   = 2'd2,
    CFG_CAP    = 2'd3
  } cfg_index_t;

  localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_ONE  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_TWO  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_THREE = 2'd3;

  localparam logic [CFG_W-1:0] UPPER_RESET  = 8'd100;
  localparam logic [CFG_W-1:0] MIDDLE_RESET = 8'd50;
  localparam logic [CFG_W-1:0] STEP_RESET   = 8'd10;
  localparam logic [CFG_W-1:0] CAP_RESET    = 8'd149;

  typedef struct packed {
    logic [CFG_W-1:0] upper;
    logic [CFG_W-1:0] middle;
    logic [CFG_W-1:0] step;
    logic [CFG_W-1:0] cap;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/mlfq_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlfq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/mlfq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Scan sequencer: walks the slot memory once per pass, tracks the best
// candidate per level, and updates valid bits, stamps and entries.
// ----------------------------------------------------------------------------
module mlfq_ctrl #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mlfq_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [ID_BITS-1:0]           in_id,
  input  wire logic [7:0]                   in_prio,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              found,
  output logic [ID_BITS-1:0]                chosen_id,
  output logic [7:0]                        chosen_priority,
  output logic [1:0]                        chosen_level,
  output logic                              dropped,
  output logic [$clog2(SLOTS+1)-1:0]        occupancy
);
  import mlfq_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS+1);
  localparam int MW = ID_BITS + PRIO_W + LEVEL_W + STAMP_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_POST, S_OUT} state_t;
  typedef enum logic [2:0] {P_INS, P_DISP, P_AGE, P_MIG3, P_MIG2, P_NOP} pass_t;

  typedef struct packed {
    logic               vld;
    logic [AW-1:0]      idx;
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0] age;
  } best_t;

  state_t             state;
  pass_t              pass;
  logic [CW-1:0]      cnt;
  logic               rd_vld;
  logic [AW-1:0]      rd_idx;
  logic [SLOTS-1:0]   valid;
  logic [STAMP_W-1:0] next_stamp;
  logic [CW-1:0]      occ;
  logic [ID_BITS-1:0] item_id;
  logic [PRIO_W-1:0]  item_prio;
  best_t              best [4];
  logic               free_vld;
  logic [AW-1:0]      free_idx;
  logic               res_found;
  logic [ID_BITS-1:0] res_id;
  logic [PRIO_W-1:0]  res_prio;
  logic [LEVEL_W-1:0] res_lvl;
  logic               res_drop;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [MW-1:0]      mem_wdata;
  logic [MW-1:0]      mem_rdata;

  logic [ID_BITS-1:0] r_id;
  logic [PRIO_W-1:0]  r_prio;
  logic [LEVEL_W-1:0] r_lvl;
  logic [STAMP_W-1:0] r_stamp;
  logic [STAMP_W-1:0] r_age;
  logic               r_v;
  logic [PRIO_W:0]    r_sum;
  logic [PRIO_W-1:0]  r_aged;
  logic [3:0]         take;
  logic [LEVEL_W-1:0] mig_from;
  logic [LEVEL_W-1:0] mig_to;
  logic [PRIO_W-1:0]  mig_thr;
  logic [LEVEL_W-1:0] ins_lvl;
  logic [LEVEL_W-1:0] pick_lvl;
  logic               scan_done;

  mlfq_mem #(.DEPTH(SLOTS), .WIDTH(MW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    r_id     = mem_rdata[ID_BITS-1:0];
    r_prio   = mem_rdata[ID_BITS +: PRIO_W];
    r_lvl    = mem_rdata[ID_BITS+PRIO_W +: LEVEL_W];
    r_stamp  = mem_rdata[ID_BITS+PRIO_W+LEVEL_W +: STAMP_W];
    r_age    = next_stamp - r_stamp;
    r_v      = valid[rd_idx];
    r_sum    = {1'b0, r_prio} + {1'b0, cfg.step};
    r_aged   = (r_sum <= {1'b0, cfg.cap}) ? r_sum[PRIO_W-1:0] : cfg.cap;
    mig_from = (pass == P_MIG3) ? LVL_THREE : LVL_TWO;
    mig_to   = (pass == P_MIG3) ? LVL_TWO : LVL_ONE;
    mig_thr  = (pass == P_MIG3) ? cfg.middle : cfg.upper;
    scan_done = (cnt == CW'(SLOTS)) && !rd_vld;

    take = '0;
    take[0] = r_v && (r_lvl == mig_from) && (r_prio >= mig_thr) &&
              (!best[0].vld || (r_age > best[0].age));
    for (int l = 1; l < 3; l++) begin
      if (r_v && (r_lvl == LEVEL_W'(l))) begin
        if (!best[l].vld) begin
          take[l] = 1'b1;
        end else if (r_prio != best[l].prio) begin
          take[l] = r_prio > best[l].prio;
        end else begin
          take[l] = r_age > best[l].age;
        end
      end
    end
    take[3] = r_v && (r_lvl == LVL_THREE) && (!best[3].vld || (r_age > best[3].age));

    priority if (item_prio >= cfg.upper) ins_lvl = LVL_ONE;
    else if (item_prio >= cfg.middle)     ins_lvl = LVL_TWO;
    else                                  ins_lvl = LVL_THREE;

    priority if (best[1].vld) pick_lvl = LVL_ONE;
    else if (best[2].vld)     pick_lvl = LVL_TWO;
    else if (best[3].vld)     pick_lvl = LVL_THREE;
    else                      pick_lvl = LVL_NONE;

    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = {r_stamp, r_lvl, r_aged, r_id};
    if (state == S_SCAN && pass == P_AGE && rd_vld && r_v) begin
      mem_we = 1'b1;
    end else if (state == S_POST && pass == P_INS && free_vld) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx;
      mem_wdata = {next_stamp, ins_lvl, item_prio, item_id};
    end else if (state == S_POST && (pass == P_MIG3 || pass == P_MIG2) && best[0].vld) begin
      mem_we    = 1'b1;
      mem_waddr = best[0].idx;
      mem_wdata = {next_stamp, mig_to, best[0].prio, best[0].id};
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pass       <= P_NOP;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      valid      <= '0;
      next_stamp <= '0;
      occ        <= '0;
      out_valid  <= 1'b0;
      free_vld   <= 1'b0;
      for (int l = 0; l < 4; l++) best[l].vld <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_id   <= in_id;
            item_prio <= in_prio;
            res_found <= 1'b0;
            res_id    <= '0;
            res_prio  <= '0;
            res_lvl   <= LVL_NONE;
            res_drop  <= 1'b0;
            cnt       <= '0;
            rd_vld    <= 1'b0;
            free_vld  <= 1'b0;
            for (int l = 0; l < 4; l++) best[l].vld <= 1'b0;
            unique case (mode_t'(in_mode))
              MODE_INSERT:   begin pass <= P_INS;  state <= S_SCAN; end
              MODE_DISPATCH: begin pass <= P_DISP; state <= S_SCAN; end
              MODE_AGE:      begin pass <= P_AGE;  state <= S_SCAN; end
              MODE_NOP:      begin pass <= P_NOP;  state <= S_POST; end
            endcase
          end
        end
        S_SCAN: begin
          if (cnt != CW'(SLOTS)) cnt <= cnt + 1'b1;
          rd_vld <= (cnt != CW'(SLOTS));
          rd_idx <= cnt[AW-1:0];
          if (rd_vld) begin
            if (pass == P_INS && !r_v && !free_vld) begin
              free_vld <= 1'b1;
              free_idx <= rd_idx;
            end
            for (int l = 0; l < 4; l++) begin
              if (take[l] && (l == 0 ? (pass == P_MIG3 || pass == P_MIG2)
                                     : (pass == P_DISP))) begin
                best[l] <= '{vld: 1'b1, idx: rd_idx, id: r_id, prio: r_prio, age: r_age};
              end
            end
          end
          if (scan_done) state <= S_POST;
        end
        S_POST: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
          for (int l = 0; l < 4; l++) best[l].vld <= 1'b0;
          state  <= S_OUT;
          unique case (pass)
            P_INS: begin
              if (free_vld) begin
                valid[free_idx] <= 1'b1;
                occ        <= occ + 1'b1;
                next_stamp <= next_stamp + 1'b1;
              end else begin
                res_drop <= 1'b1;
              end
            end
            P_DISP: begin
              if (pick_lvl != LVL_NONE) begin
                valid[best[pick_lvl].idx] <= 1'b0;
                occ       <= occ - 1'b1;
                res_found <= 1'b1;
                res_id    <= best[pick_lvl].id;
                res_prio  <= best[pick_lvl].prio;
                res_lvl   <= pick_lvl;
              end
            end
            P_AGE: begin
              pass  <= P_MIG3;
              state <= S_SCAN;
            end
            P_MIG3, P_MIG2: begin
              if (best[0].vld) begin
                next_stamp <= next_stamp + 1'b1;
                state      <= S_SCAN;
              end else if (pass == P_MIG3) begin
                pass  <= P_MIG2;
                state <= S_SCAN;
              end
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            found           <= res_found;
            chosen_id       <= res_id;
            chosen_priority <= res_prio;
            chosen_level    <= res_lvl;
            dropped         <= res_drop;
            occupancy       <= occ;
            state           <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/multilevel_feedback_queue_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Three-level ready queue of tasks with priority dispatch and aging.
// Insert and dispatch: one scan of the slot memory; a new transfer is taken
//   only after the result has been loaded into the output register.
// Aging tick: one update scan plus one scan per migrated task and one per
//   level pass; an idle code runs no scan.
// The slot memory has a single read port.
// Reset clears valid bits, stamp counter and output; config returns to
//   defaults. No clearing pass.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8,
  localparam int OW     = $clog2(SLOTS+1),
  localparam int IN_W   = ((10 + ID_BITS + 7) / 8) * 8,
  localparam int OUT_W  = ((12 + ID_BITS + OW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_addr,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // mode, task_id, task_priority
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // found, chosen_id, chosen_priority, chosen_level, dropped, occupancy
  output logic [OUT_W-1:0]      m_tdata
);
  import mlfq_pkg::*;

  cfg_t               cfg;
  logic               found;
  logic [ID_BITS-1:0] chosen_id;
  logic [7:0]         chosen_priority;
  logic [1:0]         chosen_level;
  logic               dropped;
  logic [OW-1:0]      occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{upper: UPPER_RESET, middle: MIDDLE_RESET, step: STEP_RESET, cap: CAP_RESET};
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_addr))
        CFG_UPPER:  cfg.upper  <= cfg_wdata;
        CFG_MIDDLE: cfg.middle <= cfg_wdata;
        CFG_STEP:   cfg.step   <= cfg_wdata;
        CFG_CAP:    cfg.cap    <= cfg_wdata;
      endcase
    end
  end

  mlfq_ctrl #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_mode         (s_tdata[1:0]),
    .in_id           (s_tdata[2 +: ID_BITS]),
    .in_prio         (s_tdata[2+ID_BITS +: 8]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .found           (found),
    .chosen_id       (chosen_id),
    .chosen_priority (chosen_priority),
    .chosen_level    (chosen_level),
    .dropped         (dropped),
    .occupancy       (occupancy)
  );

  assign m_tdata = OUT_W'({occupancy, dropped, chosen_level, chosen_priority,
                           chosen_id, found});

endmodule
`default_nettype wire

@@ src/mlfq_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_chk
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlfq_chk #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8,
  localparam int OW     = $clog2(SLOTS+1),
  localparam int IN_W   = ((10 + ID_BITS + 7) / 8) * 8,
  localparam int OUT_W  = ((12 + ID_BITS + OW + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             cfg_we,
  input wire logic [1:0]       cfg_addr,
  input wire logic [7:0]       cfg_wdata,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [IN_W-1:0]  s_tdata,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  localparam int LVL_LO = 9 + ID_BITS;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[LVL_LO+1:1] == '0)
    else $error("chosen fields nonzero without a dispatched task");

  a_found_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[LVL_LO+1:LVL_LO] != 2'd0 && !m_tdata[LVL_LO+2])
    else $error("dispatched task without level or with drop flag");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_chk #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_chk (.*);
`default_nettype wire

@@ verif/mlfq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_checker
// Watches the configuration port and both streams of the scheduler, keeps a
// shadow copy of the task slots and compares every result with its forecast.
// ----------------------------------------------------------------------------
module mlfq_checker
  import mlfq_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int IN_W  = 24,
  parameter int OUT_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [7:0]       cfg_wdata,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [4:0] occupancy;
    logic       dropped;
    logic [1:0] level;
    logic [7:0] prio;
    logic [7:0] id;
    logic       found;
  } sched_result_t;

  bit          used_q[SLOTS];
  logic [7:0]  id_q[SLOTS];
  logic [7:0]  prio_q[SLOTS];
  logic [1:0]  lvl_q[SLOTS];
  logic [15:0] stamp_q[SLOTS];
  logic [15:0] stamp_next;
  cfg_t        regs;
  sched_result_t expected_results[$];

  function automatic logic [15:0] wait_len(int s);
    return stamp_next - stamp_q[s];
  endfunction

  function automatic void restamp(int s);
    stamp_q[s] = stamp_next;
    stamp_next = stamp_next + 16'd1;
  endfunction

  function automatic int best_at(logic [1:0] lvl, bit by_prio);
    int best;
    best = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (!used_q[s] || lvl_q[s] != lvl) continue;
      if (best < 0) begin
        best = s;
        continue;
      end
      if (by_prio && prio_q[s] != prio_q[best]) begin
        if (prio_q[s] > prio_q[best]) best = s;
        continue;
      end
      if (wait_len(s) > wait_len(best)) best = s;
    end
    return best;
  endfunction

  function automatic void promote(logic [1:0] from, logic [1:0] to, logic [7:0] thr);
    int best;
    for (int n = 0; n < SLOTS; n++) begin
      best = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (!used_q[s] || lvl_q[s] != from || prio_q[s] < thr) continue;
        if (best < 0 || wait_len(s) > wait_len(best)) best = s;
      end
      if (best < 0) return;
      lvl_q[best] = to;
      restamp(best);
    end
  endfunction

  function automatic sched_result_t schedule(logic [1:0] mode, logic [7:0] tid,
                                             logic [7:0] tprio);
    sched_result_t r;
    int c;
    int sum;
    r = '0;
    c = -1;
    case (mode)
      MODE_INSERT: begin
        for (int s = 0; s < SLOTS; s++)
          if (!used_q[s]) begin
            c = s;
            break;
          end
        if (c < 0) begin
          r.dropped = 1'b1;
        end else begin
          used_q[c] = 1'b1;
          id_q[c] = tid;
          prio_q[c] = tprio;
          if (tprio >= regs.upper) lvl_q[c] = LVL_ONE;
          else if (tprio >= regs.middle) lvl_q[c] = LVL_TWO;
          else lvl_q[c] = LVL_THREE;
          restamp(c);
        end
      end
      MODE_DISPATCH: begin
        c = best_at(LVL_ONE, 1'b1);
        if (c < 0) c = best_at(LVL_TWO, 1'b1);
        if (c < 0) c = best_at(LVL_THREE, 1'b0);
        if (c >= 0) begin
          r.found = 1'b1;
          r.id = id_q[c];
          r.prio = prio_q[c];
          r.level = lvl_q[c];
          used_q[c] = 1'b0;
        end
      end
      MODE_AGE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!used_q[s]) continue;
          sum = int'(prio_q[s]) + int'(regs.step);
          prio_q[s] = (sum <= int'(regs.cap)) ? sum[7:0] : regs.cap;
        end
        promote(LVL_THREE, LVL_TWO, regs.middle);
        promote(LVL_TWO, LVL_ONE, regs.upper);
      end
      default: ;
    endcase
    for (int s = 0; s < SLOTS; s++) r.occupancy += used_q[s];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) used_q[s] = 1'b0;
      stamp_next = '0;
      regs = '{UPPER_RESET, MIDDLE_RESET, STEP_RESET, CAP_RESET};
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_addr))
          CFG_UPPER:  regs.upper = cfg_wdata;
          CFG_MIDDLE: regs.middle = cfg_wdata;
          CFG_STEP:   regs.step = cfg_wdata;
          CFG_CAP:    regs.cap = cfg_wdata;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(sched_result_t)-1:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.id !== want.id || got.prio !== want.prio ||
              got.level !== want.level || got.dropped !== want.dropped ||
              got.occupancy !== want.occupancy) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(schedule(s_tdata[1:0], s_tdata[9:2], s_tdata[17:10]));
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives task inserts, dispatches and aging ticks into the scheduler under
// random stream gaps and sweeps the configuration between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mlfq_pkg::*;

  localparam int SLOTS = 16;
  localparam int IN_W  = 24;
  localparam int OUT_W = 32;
  localparam int LIMIT = 3000000;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [1:0]      cfg_addr;
  logic [7:0]      cfg_wdata;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [OUT_W-1:0] m_tdata;
  int              errors;
  int              pending;
  int              cycles;
  bit              calm;
  bit              hold_off;

  multilevel_feedback_queue_scheduler #(.SLOTS(SLOTS), .ID_BITS(8)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  mlfq_checker #(.SLOTS(SLOTS), .IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // valid stays up after a transfer until the next item, a gap or a drain
  task automatic send_item(mode_t mode, logic [7:0] tid, logic [7:0] tprio);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, tprio, tid, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item(int ins_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_weight)
      send_item(MODE_INSERT, 8'($urandom), 8'($urandom));
    else if (r < ins_weight + 30)
      send_item(MODE_DISPATCH, 8'($urandom), 8'($urandom));
    else if (r < 97)
      send_item(MODE_AGE, 8'($urandom), 8'($urandom));
    else
      send_item(MODE_NOP, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    cycles = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty dispatch, levels, ties, full store, saturation, nop
    send_item(MODE_DISPATCH, 8'hff, 8'hff);
    send_item(MODE_INSERT, 8'h00, 8'h00);
    send_item(MODE_INSERT, 8'hff, 8'hff);
    send_item(MODE_INSERT, 8'h11, 8'd100);
    send_item(MODE_INSERT, 8'h12, 8'd100);
    send_item(MODE_INSERT, 8'h21, 8'd50);
    send_item(MODE_INSERT, 8'h31, 8'd49);
    for (int i = 0; i < 11; i++) send_item(MODE_INSERT, 8'(i + 8'h40), 8'(i * 9));
    send_item(MODE_AGE, 8'h00, 8'h00);
    send_item(MODE_NOP, 8'hff, 8'hff);
    for (int i = 0; i < 5; i++) send_item(MODE_DISPATCH, 8'h00, 8'h00);
    drain();

    // random phases across settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_UPPER, 8'd255); write_reg(CFG_MIDDLE, 8'd0);
          write_reg(CFG_STEP, 8'd255); write_reg(CFG_CAP, 8'd255);
        end
        2: begin
          write_reg(CFG_UPPER, 8'd0); write_reg(CFG_MIDDLE, 8'd255);
          write_reg(CFG_STEP, 8'd0); write_reg(CFG_CAP, 8'd0);
        end
        3: begin
          write_reg(CFG_UPPER, 8'd30); write_reg(CFG_MIDDLE, 8'd200);
          write_reg(CFG_STEP, 8'd1); write_reg(CFG_CAP, 8'd128);
        end
        default: begin
          write_reg(CFG_UPPER, 8'($urandom_range(100, 255)));
          write_reg(CFG_MIDDLE, 8'($urandom_range(0, 120)));
          write_reg(CFG_STEP, 8'($urandom_range(0, 40)));
          write_reg(CFG_CAP, 8'($urandom));
        end
      endcase
      if (ph == 2) hold_off = 1'b1;
      calm = (ph == 7);
      for (int i = 0; i < 160; i++) random_item(ph[0] ? 55 : 40);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
